// ===== src/txcon_pkg.sv =====
// Shared types and constants of the text console.
package txcon_pkg;

   localparam int KIND_W   = 1;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 12;
   localparam int CURSOR_W = 12;

   localparam logic [KIND_W-1:0] KIND_PRINT = 1'b0;
   localparam logic [KIND_W-1:0] KIND_READ  = 1'b1;

   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd0;

   // cursor commands from the sequencer
   typedef struct packed {
      logic step;   // advance by one cell
      logic home;   // back to the start of the row
      logic fold;   // last step of the item: scroll back if past the end
   } txcon_cmd_type;

   // flags of the step that the cursor would take this cycle
   typedef struct packed {
      logic col_wrap;   // step lands on a row start
      logic tab_wrap;   // step lands on a tab stop
      logic past_end;   // step lands beyond the last cell
   } txcon_stat_type;

endpackage

// ===== src/txcon_cell_ram.sv =====
// Character cell store: one write port, one registered read port.
module txcon_cell_ram
   import txcon_pkg::*;
#(
   parameter int DEPTH = 2400,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [CHAR_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/txcon_cursor.sv =====
// Cursor position with its row start, column and tab phase.
module txcon_cursor
   import txcon_pkg::*;
#(
   parameter int COLUMNS   = 80,
   parameter int CELLS     = 2400,
   parameter int TAB_WIDTH = 8,
   localparam int CUR_W = $clog2(CELLS + COLUMNS + TAB_WIDTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  txcon_cmd_type    cmd,
   output txcon_stat_type   stat,
   output logic [CUR_W-1:0] cursor
);

   localparam int  COL_W     = $clog2(COLUMNS);
   localparam int  TM_W      = $clog2(TAB_WIDTH);
   localparam bit  WIDE      = (COLUMNS >= CELLS);
   localparam int  COL_MOD   = COLUMNS % TAB_WIDTH;
   localparam int  DOWN_COL  = (TAB_WIDTH - COL_MOD) % TAB_WIDTH;
   localparam int  DOWN_CELL = (TAB_WIDTH - (CELLS % TAB_WIDTH)) % TAB_WIDTH;
   localparam int  SAT_RB    = ((CELLS - 1) / COLUMNS) * COLUMNS;
   localparam int  SAT_COL   = (CELLS - 1) % COLUMNS;
   localparam int  SAT_TM    = (CELLS - 1) % TAB_WIDTH;
   localparam int  SAT_RBT   = SAT_RB % TAB_WIDTH;

   logic [CUR_W-1:0] cur_ff, cur_in, rb_ff, rb_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [TM_W-1:0]  tm_ff, tm_in, rbt_ff, rbt_in;

   logic [CUR_W-1:0] st_cur, st_rb, sc_cur;
   logic [COL_W-1:0] st_col;
   logic [TM_W-1:0]  st_tm, st_rbt;

   // a + k modulo the tab width, both below it
   function automatic logic [TM_W-1:0] mod_add(input logic [TM_W-1:0] a,
                                               input logic [TM_W-1:0] k);
      logic [TM_W:0] s;
      s = {1'b0, a} + {1'b0, k};
      if (s >= (TM_W+1)'(TAB_WIDTH)) begin
         s = s - (TM_W+1)'(TAB_WIDTH);
      end
      return s[TM_W-1:0];
   endfunction

   always_comb begin
      stat.col_wrap = (col_ff == COL_W'(COLUMNS - 1));
      stat.tab_wrap = (tm_ff == TM_W'(TAB_WIDTH - 1));

      st_cur = cur_ff + CUR_W'(1);
      st_col = stat.col_wrap ? '0 : col_ff + COL_W'(1);
      st_rb  = stat.col_wrap ? rb_ff + CUR_W'(COLUMNS) : rb_ff;
      st_rbt = stat.col_wrap ? mod_add(rbt_ff, TM_W'(COL_MOD)) : rbt_ff;
      st_tm  = stat.tab_wrap ? '0 : tm_ff + TM_W'(1);

      stat.past_end = (st_cur >= CUR_W'(CELLS));

      if (WIDE) begin
         sc_cur = st_cur - CUR_W'(CELLS);
      end else begin
         sc_cur = st_cur - CUR_W'(COLUMNS);
      end

      cur_in = cur_ff;
      rb_in  = rb_ff;
      col_in = col_ff;
      tm_in  = tm_ff;
      rbt_in = rbt_ff;

      if (cmd.step) begin
         if (cmd.fold && stat.past_end) begin
            if (sc_cur >= CUR_W'(CELLS)) begin
               // still past the end after one scroll: pin to the last cell
               cur_in = CUR_W'(CELLS - 1);
               rb_in  = CUR_W'(SAT_RB);
               col_in = COL_W'(SAT_COL);
               tm_in  = TM_W'(SAT_TM);
               rbt_in = TM_W'(SAT_RBT);
            end else if (WIDE) begin
               // whole store shifted out: cursor lands in the top row
               cur_in = sc_cur;
               rb_in  = '0;
               col_in = sc_cur[COL_W-1:0];
               tm_in  = mod_add(st_tm, TM_W'(DOWN_CELL));
               rbt_in = '0;
            end else begin
               cur_in = sc_cur;
               rb_in  = st_rb - CUR_W'(COLUMNS);
               col_in = st_col;
               tm_in  = mod_add(st_tm, TM_W'(DOWN_COL));
               rbt_in = mod_add(st_rbt, TM_W'(DOWN_COL));
            end
         end else begin
            cur_in = st_cur;
            rb_in  = st_rb;
            col_in = st_col;
            tm_in  = st_tm;
            rbt_in = st_rbt;
         end
      end else if (cmd.home) begin
         cur_in = rb_ff;
         col_in = '0;
         tm_in  = rbt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         rb_ff  <= '0;
         col_ff <= '0;
         tm_ff  <= '0;
         rbt_ff <= '0;
      end else begin
         cur_ff <= cur_in;
         rb_ff  <= rb_in;
         col_ff <= col_in;
         tm_ff  <= tm_in;
         rbt_ff <= rbt_in;
      end
   end

   assign cursor = cur_ff;

endmodule

// ===== src/text_console_with_scroll.sv =====
// Text console top level: command sequencer around the cell store and cursor.
//
// A transaction is taken at a clock edge where start is high and busy is low;
// each one gives exactly one result on the rsp_ ports, flagged by rsp_strobe
// for a single cycle, and the receiver cannot stall it. After reset the cell
// store is swept to zero, one cell a cycle, and busy stays high until the
// sweep is done. A read waits on the registered read port, a printed byte
// on the write pipeline; a carriage return only moves the cursor. Newline
// and tab walk the cells they clear, one cell a cycle through the single
// write port, up to COLUMNS or TAB_WIDTH cells. A byte that runs the cursor
// off the end of the screen adds a scroll: each cell is read one row further
// on and written back through the registered write pipeline, the vacated
// row being written with zeros. rsp_cursor_pos is the cursor after the
// transaction and is valid while rsp_strobe is high.
module text_console_with_scroll
   import txcon_pkg::*;
#(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 30,
   parameter int CELLS     = 2400,
   parameter int TAB_WIDTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [INDEX_W-1:0]  req_cell_index,
   output logic                rsp_strobe,
   output logic [CURSOR_W-1:0] rsp_cursor_pos,
   output logic [CHAR_W-1:0]   rsp_cell_char,
   output logic                rsp_scrolled
);

   // ROWS only documents the screen shape; the store size is CELLS
   localparam int AW    = $clog2(CELLS);
   localparam int PW    = $clog2(2 * CELLS);
   localparam int CUR_W = $clog2(CELLS + COLUMNS + TAB_WIDTH + 1);
   localparam int SHIFT = (COLUMNS < CELLS) ? COLUMNS : CELLS;
   localparam int SCREEN_CELLS = ROWS * COLUMNS;

   typedef enum logic [2:0] {
      S_CLEAR,    // sweep after reset
      S_IDLE,
      S_READ,     // read data arrives
      S_WALK,     // newline / tab clearing
      S_SCROLL    // move every row up by one
   } state_type;

   state_type         state_ff;
   logic [PW-1:0]     ptr_ff;
   logic              walk_nl_ff;
   logic              rd_ok_ff;

   // write pipeline: every store write is registered before it goes out,
   // so scroll copies (which need the read data) and plain writes share a port
   logic              wq_en_ff;
   logic              wq_use_rd_ff;
   logic [AW-1:0]     wq_addr_ff;
   logic [CHAR_W-1:0] wq_data_ff;

   logic              rsp_strobe_ff;
   logic [CHAR_W-1:0] rsp_cell_ff;
   logic              rsp_scrolled_ff;

   logic              accept;
   logic              cur_in_range;
   logic [PW-1:0]     src;
   logic              src_ok;
   logic [31:0]       idx_ext;
   logic              idx_ok;
   logic [CUR_W-1:0]  cursor;

   txcon_cmd_type     cmd;
   txcon_stat_type    stat;

   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [CHAR_W-1:0] rd_data;
   logic [CHAR_W-1:0] wr_data;

   // the store must cover at least the visible screen for a sane setup;
   // the check only narrows the index compare, never widens it
   assign idx_ext = 32'(req_cell_index);
   assign idx_ok  = (idx_ext < 32'(CELLS)) && (32'(SCREEN_CELLS) > 32'd0);

   assign busy         = (state_ff != S_IDLE) || wq_en_ff;
   assign accept       = start && !busy;
   assign cur_in_range = (cursor < CUR_W'(CELLS));
   assign src          = ptr_ff + PW'(SHIFT);
   assign src_ok       = (src < PW'(CELLS));

   // cursor commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_kind == KIND_PRINT)) begin
               if (req_char_code == CH_RETURN) begin
                  cmd.home = 1'b1;
               end else if ((req_char_code != CH_NEWLINE) &&
                            (req_char_code != CH_TAB)) begin
                  cmd.step = 1'b1;
                  cmd.fold = 1'b1;
               end
            end
         end
         S_WALK: begin
            cmd.step = 1'b1;
            cmd.fold = walk_nl_ff ? stat.col_wrap : stat.tab_wrap;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // store read port: scroll source or the cell asked for
   assign rd_en   = (accept && (req_kind == KIND_READ)) ||
                    ((state_ff == S_SCROLL) && src_ok);
   assign rd_addr = (state_ff == S_SCROLL) ? src[AW-1:0] : idx_ext[AW-1:0];
   assign wr_data = wq_use_rd_ff ? rd_data : wq_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ptr_ff        <= '0;
         wq_en_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         wq_en_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               wq_en_ff     <= 1'b1;
               wq_use_rd_ff <= 1'b0;
               wq_data_ff   <= CH_BLANK;
               wq_addr_ff   <= ptr_ff[AW-1:0];
               if (ptr_ff == PW'(CELLS - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  ptr_ff <= ptr_ff + PW'(1);
               end
            end
            S_IDLE: begin
               if (accept) begin
                  if (req_kind == KIND_READ) begin
                     rd_ok_ff <= idx_ok;
                     state_ff <= S_READ;
                  end else begin
                     case (req_char_code)
                        CH_NEWLINE, CH_TAB: begin
                           walk_nl_ff <= (req_char_code == CH_NEWLINE);
                           state_ff   <= S_WALK;
                        end
                        CH_RETURN: begin
                           rsp_strobe_ff   <= 1'b1;
                           rsp_cell_ff     <= CH_BLANK;
                           rsp_scrolled_ff <= 1'b0;
                        end
                        default: begin
                           wq_en_ff     <= cur_in_range;
                           wq_use_rd_ff <= 1'b0;
                           wq_data_ff   <= req_char_code;
                           wq_addr_ff   <= cursor[AW-1:0];
                           if (stat.past_end) begin
                              ptr_ff   <= '0;
                              state_ff <= S_SCROLL;
                           end else begin
                              rsp_strobe_ff   <= 1'b1;
                              rsp_cell_ff     <= CH_BLANK;
                              rsp_scrolled_ff <= 1'b0;
                           end
                        end
                     endcase
                  end
               end
            end
            S_READ: begin
               rsp_strobe_ff   <= 1'b1;
               rsp_cell_ff     <= rd_ok_ff ? rd_data : CH_BLANK;
               rsp_scrolled_ff <= 1'b0;
               state_ff        <= S_IDLE;
            end
            S_WALK: begin
               // cells past the end of the store are skipped
               wq_en_ff     <= cur_in_range;
               wq_use_rd_ff <= 1'b0;
               wq_data_ff   <= CH_BLANK;
               wq_addr_ff   <= cursor[AW-1:0];
               if (cmd.fold) begin
                  if (stat.past_end) begin
                     ptr_ff   <= '0;
                     state_ff <= S_SCROLL;
                  end else begin
                     rsp_strobe_ff   <= 1'b1;
                     rsp_cell_ff     <= CH_BLANK;
                     rsp_scrolled_ff <= 1'b0;
                     state_ff        <= S_IDLE;
                  end
               end
            end
            S_SCROLL: begin
               // write pointer trails the read by SHIFT cells, so a copy
               // never reads a cell that has already been overwritten
               wq_en_ff     <= 1'b1;
               wq_use_rd_ff <= src_ok;
               wq_data_ff   <= CH_BLANK;
               wq_addr_ff   <= ptr_ff[AW-1:0];
               if (ptr_ff == PW'(CELLS - 1)) begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_cell_ff     <= CH_BLANK;
                  rsp_scrolled_ff <= 1'b1;
                  state_ff        <= S_IDLE;
               end else begin
                  ptr_ff <= ptr_ff + PW'(1);
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   txcon_cell_ram #(
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wq_en_ff),
      .wr_addr (wq_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   txcon_cursor #(
      .COLUMNS   (COLUMNS),
      .CELLS     (CELLS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_cursor (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (stat),
      .cursor (cursor)
   );

   // cursor register already holds the post-transaction value in the strobe cycle
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cursor_pos = CURSOR_W'(cursor);
   assign rsp_cell_char  = rsp_cell_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

endmodule
